// ===== sv/mabs_pkg.sv =====
// ----------------------------------------------------------------------------
// mabs_pkg: shared constants and types for the moving average band signal
// field widths, register map, reset values and the result queue entry
// ----------------------------------------------------------------------------
package mabs_pkg;

   localparam int NUM_SYMBOLS_DEF = 16;
   localparam int MAX_WINDOW_DEF  = 64;

   localparam int SYM_FIELD_W = 4;
   localparam int PRICE_W     = 32;
   localparam int QTY_W       = 32;
   localparam int WIN_REG_W   = 7;
   localparam int BAND_W      = 16;
   localparam int SUM_W       = 38;
   localparam int Q16_W       = 17;
   localparam int FRAC_BITS   = 16;

   localparam logic [Q16_W-1:0] Q16_ONE = 17'h10000;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 72;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 7'd20;
   localparam logic [BAND_W-1:0]    BAND_RESET   = 16'd3277;
   localparam logic [QTY_W-1:0]     QTY_RESET    = 32'd10000;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic MODE_QUOTE = 1'b0;
   localparam logic SIDE_BUY   = 1'b0;
   localparam logic SIDE_SELL  = 1'b1;

   typedef enum logic [1:0] {
      REG_WINDOW = 2'd0,
      REG_BAND   = 2'd1,
      REG_QTY    = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [PRICE_W-1:0]     price;
      logic                   side;
      logic [SYM_FIELD_W-1:0] sym;
   } result_type;

endpackage

// ===== sv/moving_average_band_signal_core.sv =====
// ----------------------------------------------------------------------------
// moving_average_band_signal_core: per-symbol mean reversion band trigger
// structure: a 4-stage pipe, then the result queue that drives rsp_tvalid
// throughput: one request per cycle while result queue credit allows; forwarding on the state memories closes the loop
// reset: synchronous, clears control, config and per-symbol valid bits; no clearing pass
// ----------------------------------------------------------------------------
module moving_average_band_signal_core #(
   parameter int NUM_SYMBOLS = mabs_pkg::NUM_SYMBOLS_DEF,
   parameter int MAX_WINDOW  = mabs_pkg::MAX_WINDOW_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // symbol_index[3:0], price[35:4], fill_side[36], fill_done[37]
   input  logic [mabs_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // mode
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // intent_symbol[3:0], intent_quantity[35:4], quote_price[67:36]
   output logic [mabs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // intent_side
   output logic                              rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mabs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mabs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mabs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   import mabs_pkg::*;

   localparam int SYM_W      = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
   localparam int SLOT_W     = $clog2(MAX_WINDOW);
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int RING_DEPTH = NUM_SYMBOLS * MAX_WINDOW;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int LHS_W      = PRICE_W + CNT_W;
   localparam int PROD_W     = SUM_W + Q16_W;
   localparam int CMP_W      = (LHS_W + FRAC_BITS > PROD_W) ? LHS_W + FRAC_BITS : PROD_W;
   localparam int FCNT_W     = FIFO_AW + 1;

   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [SLOT_W-1:0] slot;
      logic              flag;
   } ctl_type;

   // configuration registers
   logic [WIN_REG_W-1:0] window_ff;
   logic [BAND_W-1:0]    band_ff;
   logic [QTY_W-1:0]     qty_ff;
   logic                 csr_wr;

   // request decode
   logic [SYM_FIELD_W-1:0] req_sym;
   logic [PRICE_W-1:0]     req_price;
   logic                   req_fire;
   logic                   req_in_range;

   // stage 1
   logic                p1_vld_ff;
   logic [SYM_W-1:0]    p1_sym_ff;
   logic                p1_quote_ff;
   logic [PRICE_W-1:0]  p1_price_ff;
   logic                p1_side_ff;
   logic                p1_done_ff;
   ctl_type             ctl_rd_ff;
   logic                ctl_rd_vld_ff;
   ctl_type             ctl_mem [NUM_SYMBOLS];
   logic [NUM_SYMBOLS-1:0] ctl_vld_ff;
   logic                fwd_ctl_vld_ff;
   logic [SYM_W-1:0]    fwd_ctl_sym_ff;
   ctl_type             fwd_ctl_ff;
   ctl_type             ctl_cur;
   ctl_type             ctl_in;
   logic                ctl_we;
   logic [CNT_W-1:0]    win;
   logic [SLOT_W-1:0]   slot_cur;
   logic [CNT_W-1:0]    slot_inc;
   logic [SLOT_W-1:0]   slot_new;
   logic [CNT_W-1:0]    count_new;
   logic                full_before;
   logic                full_after;
   logic [RING_AW-1:0]  ring_addr;
   logic                ring_we;
   logic [PRICE_W-1:0]  ring_mem [RING_DEPTH];
   logic [PRICE_W-1:0]  ring_rd_ff;

   // stage 2
   logic                p2_vld_ff;
   logic                p2_quote_ff;
   logic [SYM_W-1:0]    p2_sym_ff;
   logic [PRICE_W-1:0]  p2_price_ff;
   logic [CNT_W-1:0]    p2_win_ff;
   logic                p2_flag_ff;
   logic                p2_full_before_ff;
   logic                p2_full_after_ff;
   logic [SUM_W-1:0]    sum_mem [NUM_SYMBOLS];
   logic [NUM_SYMBOLS-1:0] sum_vld_ff;
   logic [SUM_W-1:0]    sum_rd_ff;
   logic                sum_rd_vld_ff;
   logic                fwd_sum_vld_ff;
   logic [SYM_W-1:0]    fwd_sum_sym_ff;
   logic [SUM_W-1:0]    fwd_sum_ff;
   logic [SUM_W-1:0]    sum_cur;
   logic [SUM_W-1:0]    sum_in;
   logic                sum_we;

   // stage 3
   logic                p3_vld_ff;
   logic [SYM_W-1:0]    p3_sym_ff;
   logic [PRICE_W-1:0]  p3_price_ff;
   logic [CNT_W-1:0]    p3_win_ff;
   logic                p3_flag_ff;
   logic [SUM_W-1:0]    p3_sum_ff;
   logic [LHS_W-1:0]    lhs_in;
   logic [PROD_W-1:0]   lo_in;
   logic [PROD_W-1:0]   hi_in;

   // stage 4
   logic                p4_vld_ff;
   logic [SYM_W-1:0]    p4_sym_ff;
   logic [PRICE_W-1:0]  p4_price_ff;
   logic                p4_flag_ff;
   logic [LHS_W-1:0]    p4_lhs_ff;
   logic [PROD_W-1:0]   p4_lo_ff;
   logic [PROD_W-1:0]   p4_hi_ff;
   logic [CMP_W-1:0]    lhs_cmp;
   logic                buy;
   logic                sell;

   // result queue
   result_type          fifo_mem [FIFO_DEPTH];
   result_type          fifo_entry;
   result_type          fifo_head;
   logic [FIFO_AW-1:0]  wr_ptr_ff;
   logic [FIFO_AW-1:0]  rd_ptr_ff;
   logic [FCNT_W-1:0]   fifo_cnt_ff;
   logic [FCNT_W-1:0]   fifo_cnt_in;
   logic                fifo_push;
   logic                fifo_pop;
   logic [FCNT_W:0]     credit_used;

   // ------------------------------------------------------------------------
   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         band_ff   <= BAND_RESET;
         qty_ff    <= QTY_RESET;
      end else if (csr_wr) begin
         unique case (csr_reg_type'(csr_paddr[3:2]))
            REG_WINDOW: window_ff <= csr_pwdata[WIN_REG_W-1:0];
            REG_BAND:   band_ff   <= csr_pwdata[BAND_W-1:0];
            REG_QTY:    qty_ff    <= csr_pwdata[QTY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg_type'(csr_paddr[3:2]))
         REG_WINDOW: csr_prdata = CSR_DATA_W'(window_ff);
         REG_BAND:   csr_prdata = CSR_DATA_W'(band_ff);
         REG_QTY:    csr_prdata = CSR_DATA_W'(qty_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // effective window, clamped to 1..MAX_WINDOW
   always_comb begin
      if (window_ff == '0) begin
         win = CNT_W'(1);
      end else if (32'(window_ff) > MAX_WINDOW) begin
         win = CNT_W'(MAX_WINDOW);
      end else begin
         win = CNT_W'(window_ff);
      end
   end

   // ------------------------------------------------------------------------
   // request intake
   assign req_sym      = req_tdata[SYM_FIELD_W-1:0];
   assign req_price    = req_tdata[SYM_FIELD_W +: PRICE_W];
   assign req_fire     = req_tvalid && req_tready;
   assign req_in_range = 32'(req_sym) < NUM_SYMBOLS;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= req_fire && req_in_range;
      end
   end

   always_ff @(posedge clock) begin
      p1_sym_ff   <= SYM_W'(req_sym);
      p1_quote_ff <= (req_tuser == MODE_QUOTE);
      p1_price_ff <= req_price;
      p1_side_ff  <= req_tdata[SYM_FIELD_W + PRICE_W];
      p1_done_ff  <= req_tdata[SYM_FIELD_W + PRICE_W + 1];
   end

   // ------------------------------------------------------------------------
   // stage 1: symbol control state, ring slot
   always_ff @(posedge clock) begin
      if (ctl_we) begin
         ctl_mem[p1_sym_ff] <= ctl_in;
      end
      ctl_rd_ff     <= ctl_mem[SYM_W'(req_sym)];
      ctl_rd_vld_ff <= ctl_vld_ff[SYM_W'(req_sym)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_vld_ff     <= '0;
         fwd_ctl_vld_ff <= 1'b0;
      end else begin
         if (ctl_we) begin
            ctl_vld_ff[p1_sym_ff] <= 1'b1;
         end
         fwd_ctl_vld_ff <= ctl_we;
      end
   end

   always_ff @(posedge clock) begin
      fwd_ctl_sym_ff <= p1_sym_ff;
      fwd_ctl_ff     <= ctl_in;
   end

   always_comb begin
      if (fwd_ctl_vld_ff && (fwd_ctl_sym_ff == p1_sym_ff)) begin
         ctl_cur = fwd_ctl_ff;
      end else if (ctl_rd_vld_ff) begin
         ctl_cur = ctl_rd_ff;
      end else begin
         ctl_cur = '0;
      end

      slot_cur    = (CNT_W'(ctl_cur.slot) >= win) ? '0 : ctl_cur.slot;
      full_before = (ctl_cur.count >= win);
      count_new   = full_before ? ctl_cur.count : ctl_cur.count + CNT_W'(1);
      full_after  = (count_new >= win);
      slot_inc    = CNT_W'(slot_cur) + CNT_W'(1);
      slot_new    = (slot_inc >= win) ? '0 : SLOT_W'(slot_inc);

      if (p1_quote_ff) begin
         ctl_in.count = count_new;
         ctl_in.slot  = slot_new;
         ctl_in.flag  = ctl_cur.flag;
      end else begin
         ctl_in.count = ctl_cur.count;
         ctl_in.slot  = ctl_cur.slot;
         ctl_in.flag  = (p1_side_ff == SIDE_BUY);
      end

      ctl_we    = p1_vld_ff && (p1_quote_ff || p1_done_ff);
      ring_we   = p1_vld_ff && p1_quote_ff;
      ring_addr = RING_AW'(int'(p1_sym_ff) * MAX_WINDOW + int'(slot_cur));
   end

   // read returns the entry before this cycle's write
   always_ff @(posedge clock) begin
      ring_rd_ff <= ring_mem[ring_addr];
      if (ring_we) begin
         ring_mem[ring_addr] <= p1_price_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else begin
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_quote_ff       <= p1_quote_ff;
      p2_sym_ff         <= p1_sym_ff;
      p2_price_ff       <= p1_price_ff;
      p2_win_ff         <= win;
      p2_flag_ff        <= ctl_cur.flag;
      p2_full_before_ff <= full_before;
      p2_full_after_ff  <= full_after;
   end

   // ------------------------------------------------------------------------
   // stage 2: running sum update
   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[p2_sym_ff] <= sum_in;
      end
      sum_rd_ff     <= sum_mem[p1_sym_ff];
      sum_rd_vld_ff <= sum_vld_ff[p1_sym_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff     <= '0;
         fwd_sum_vld_ff <= 1'b0;
      end else begin
         if (sum_we) begin
            sum_vld_ff[p2_sym_ff] <= 1'b1;
         end
         fwd_sum_vld_ff <= sum_we;
      end
   end

   always_ff @(posedge clock) begin
      fwd_sum_sym_ff <= p2_sym_ff;
      fwd_sum_ff     <= sum_in;
   end

   always_comb begin
      if (fwd_sum_vld_ff && (fwd_sum_sym_ff == p2_sym_ff)) begin
         sum_cur = fwd_sum_ff;
      end else if (sum_rd_vld_ff) begin
         sum_cur = sum_rd_ff;
      end else begin
         sum_cur = '0;
      end
      sum_in = sum_cur - (p2_full_before_ff ? SUM_W'(ring_rd_ff) : '0)
               + SUM_W'(p2_price_ff);
      sum_we = p2_vld_ff && p2_quote_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_vld_ff <= 1'b0;
      end else begin
         p3_vld_ff <= p2_vld_ff && p2_quote_ff && p2_full_after_ff;
      end
   end

   always_ff @(posedge clock) begin
      p3_sym_ff   <= p2_sym_ff;
      p3_price_ff <= p2_price_ff;
      p3_win_ff   <= p2_win_ff;
      p3_flag_ff  <= p2_flag_ff;
      p3_sum_ff   <= sum_in;
   end

   // ------------------------------------------------------------------------
   // stage 3: cross products
   always_comb begin
      lhs_in = LHS_W'(p3_price_ff) * LHS_W'(p3_win_ff);
      lo_in  = PROD_W'(p3_sum_ff) * PROD_W'(Q16_ONE - Q16_W'(band_ff));
      hi_in  = PROD_W'(p3_sum_ff) * PROD_W'(Q16_ONE + Q16_W'(band_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_vld_ff <= 1'b0;
      end else begin
         p4_vld_ff <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      p4_sym_ff   <= p3_sym_ff;
      p4_price_ff <= p3_price_ff;
      p4_flag_ff  <= p3_flag_ff;
      p4_lhs_ff   <= lhs_in;
      p4_lo_ff    <= lo_in;
      p4_hi_ff    <= hi_in;
   end

   // ------------------------------------------------------------------------
   // stage 4: band compare
   always_comb begin
      lhs_cmp          = CMP_W'({p4_lhs_ff, FRAC_BITS'(0)});
      buy              = (lhs_cmp < CMP_W'(p4_lo_ff)) && !p4_flag_ff;
      sell             = (lhs_cmp > CMP_W'(p4_hi_ff)) && p4_flag_ff;
      fifo_push        = p4_vld_ff && (buy || sell);
      fifo_entry.sym   = SYM_FIELD_W'(p4_sym_ff);
      fifo_entry.side  = buy ? SIDE_BUY : SIDE_SELL;
      fifo_entry.price = p4_price_ff;
   end

   // ------------------------------------------------------------------------
   // result queue and credit
   assign fifo_pop   = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (fifo_cnt_ff != '0);
   assign fifo_head  = fifo_mem[rd_ptr_ff];
   assign rsp_tdata  = RSP_TDATA_W'({fifo_head.price, qty_ff, fifo_head.sym});
   assign rsp_tuser  = fifo_head.side;

   always_comb begin
      fifo_cnt_in = fifo_cnt_ff;
      if (fifo_push && !fifo_pop) begin
         fifo_cnt_in = fifo_cnt_ff + FCNT_W'(1);
      end else if (!fifo_push && fifo_pop) begin
         fifo_cnt_in = fifo_cnt_ff - FCNT_W'(1);
      end
      credit_used = (FCNT_W + 1)'(fifo_cnt_ff) + (FCNT_W + 1)'(p1_vld_ff)
                    + (FCNT_W + 1)'(p2_vld_ff) + (FCNT_W + 1)'(p3_vld_ff)
                    + (FCNT_W + 1)'(p4_vld_ff);
      req_tready  = (credit_used < (FCNT_W + 1)'(FIFO_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_mem[wr_ptr_ff] <= fifo_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (fifo_push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (fifo_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
         fifo_cnt_ff <= fifo_cnt_in;
      end
   end

   // ------------------------------------------------------------------------
   // assertions
   a_fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> (fifo_cnt_ff != FCNT_W'(FIFO_DEPTH)))
      else $error("result queue written while full");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_used <= (FCNT_W + 1)'(FIFO_DEPTH))
      else $error("requests in flight exceed result queue space");

   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      (p1_vld_ff && p1_quote_ff) |-> (CNT_W'(slot_new) < win))
      else $error("ring slot outside window");

   a_sum_forward: assert property (@(posedge clock) disable iff (reset)
      (ctl_we && p1_quote_ff) |=> (sum_we && (p2_sym_ff == $past(p1_sym_ff))))
      else $error("quote lost between control and sum stages");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for moving_average_band_signal_core
// drives quote and fill requests into the stream input, programs the
// window, band and quantity registers, and checks every trade intent
// against a per-symbol ring, sum and holding model kept in the bench
// ----------------------------------------------------------------------------
module testbench;
   import mabs_pkg::*;

   localparam int CLOCK_PERIOD     = 20;
   localparam int RUN_LIMIT_CYCLES = 400000;
   localparam int LONG_STALL       = 300;
   localparam int SETTLE_CYCLES    = 8;
   localparam logic MODE_FILL      = 1'b1;

   typedef struct packed {
      logic [SYM_FIELD_W-1:0] sym;
      logic                   side;
      logic [QTY_W-1:0]       quantity;
      logic [PRICE_W-1:0]     quote_price;
   } intent_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // per-symbol tracker state
   logic [PRICE_W-1:0]   ring_price  [NUM_SYMBOLS_DEF][MAX_WINDOW_DEF];
   bit                   ring_filled [NUM_SYMBOLS_DEF][MAX_WINDOW_DEF];
   logic [SUM_W-1:0]     window_sum   [NUM_SYMBOLS_DEF];
   logic [WIN_REG_W-1:0] window_count [NUM_SYMBOLS_DEF];
   logic [5:0]           next_slot    [NUM_SYMBOLS_DEF];
   bit                   symbol_held  [NUM_SYMBOLS_DEF];
   logic [PRICE_W-1:0]   price_center [NUM_SYMBOLS_DEF];

   logic [WIN_REG_W-1:0] window_setting;
   logic [BAND_W-1:0]    band_setting;
   logic [QTY_W-1:0]     quantity_setting;

   intent_type pending_intents[$];
   int      mismatch_count;
   int      requests_accepted;
   int      intents_checked;
   bit      sender_steady;
   bit      receiver_steady;
   bit      long_stall_armed;

   moving_average_band_signal_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int unsigned active_window();
      if (window_setting == 0) return 1;
      if (window_setting > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
      return 32'(window_setting);
   endfunction

   // a quote here would pull an unwritten ring entry out of the sum
   function automatic bit ring_gap_ahead(input logic [SYM_FIELD_W-1:0] sym);
      int unsigned w;
      int unsigned slot;
      w = active_window();
      slot = 32'(next_slot[sym]);
      if (slot >= w) slot = 0;
      return (window_count[sym] >= w) && !ring_filled[sym][slot];
   endfunction

   task automatic track_request(input logic mode, input logic [SYM_FIELD_W-1:0] sym,
                                input logic [PRICE_W-1:0] price, input logic side,
                                input logic done);
      int unsigned w;
      int unsigned slot;
      logic [SUM_W-1:0] sum;
      logic [63:0] lhs;
      logic [63:0] lower;
      logic [63:0] upper;
      intent_type intent;
      if (mode == MODE_FILL) begin
         if (done) symbol_held[sym] = (side == SIDE_BUY);
      end else begin
         w = active_window();
         slot = 32'(next_slot[sym]);
         if (slot >= w) slot = 0;
         sum = window_sum[sym];
         if (window_count[sym] >= w) sum = sum - SUM_W'(ring_price[sym][slot]);
         else window_count[sym] = window_count[sym] + WIN_REG_W'(1);
         sum = sum + SUM_W'(price);
         ring_price[sym][slot] = price;
         ring_filled[sym][slot] = 1'b1;
         window_sum[sym] = sum;
         slot = slot + 1;
         if (slot >= w) slot = 0;
         next_slot[sym] = slot[5:0];
         if (window_count[sym] >= w) begin
            lhs = 64'(price) * 64'(w) * 64'(Q16_ONE);
            lower = 64'(sum) * (64'(Q16_ONE) - 64'(band_setting));
            upper = 64'(sum) * (64'(Q16_ONE) + 64'(band_setting));
            intent.sym = sym;
            intent.quantity = quantity_setting;
            intent.quote_price = price;
            if (lhs < lower && !symbol_held[sym]) begin
               intent.side = SIDE_BUY;
               pending_intents.push_back(intent);
            end else if (lhs > upper && symbol_held[sym]) begin
               intent.side = SIDE_SELL;
               pending_intents.push_back(intent);
            end
         end
      end
   endtask

   task automatic send_request(input logic mode, input logic [SYM_FIELD_W-1:0] sym,
                               input logic [PRICE_W-1:0] price, input logic side,
                               input logic done);
      @(negedge clock);
      while (!sender_steady && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {2'b00, done, side, price, sym};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_accepted++;
      track_request(mode, sym, price, side, done);
   endtask

   task automatic write_register(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_WINDOW: window_setting = value[WIN_REG_W-1:0];
         REG_BAND:   band_setting = value[BAND_W-1:0];
         default:    quantity_setting = value[QTY_W-1:0];
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_register(input csr_reg_type idx);
      logic [CSR_DATA_W-1:0] expected_value;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_WINDOW: expected_value = CSR_DATA_W'(window_setting);
         REG_BAND:   expected_value = CSR_DATA_W'(band_setting);
         default:    expected_value = quantity_setting;
      endcase
      if (csr_prdata !== expected_value) begin
         mismatch_count++;
         $display("%0t: register %0d readback expected %0h, got %0h",
                  $time, idx, expected_value, csr_prdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic settle_pipeline();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_intents.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_quote_stream(input int item_total, input int steady_total,
                                   input logic [SYM_FIELD_W-1:0] hot_a,
                                   input logic [SYM_FIELD_W-1:0] hot_b);
      logic [SYM_FIELD_W-1:0] sym;
      logic [PRICE_W-1:0] price;
      logic [PRICE_W-1:0] spread;
      logic mode;
      logic side;
      logic done;
      for (int n = 0; n < item_total; n++) begin
         sender_steady = (n < steady_total);
         receiver_steady = (n < steady_total);
         if ($urandom_range(0, 3) != 0) sym = ($urandom_range(0, 1) != 0) ? hot_a : hot_b;
         else sym = SYM_FIELD_W'($urandom_range(0, NUM_SYMBOLS_DEF - 1));
         mode = ($urandom_range(0, 99) < 25) ? MODE_FILL : MODE_QUOTE;
         if (mode == MODE_QUOTE && ring_gap_ahead(sym)) mode = MODE_FILL;
         side = 1'($urandom_range(0, 1));
         done = 1'($urandom_range(0, 1));
         price = $urandom;
         if (mode == MODE_FILL) begin
            // mostly the fill that closes the loop on the current position
            if ($urandom_range(0, 4) != 0) begin
               side = symbol_held[sym] ? SIDE_SELL : SIDE_BUY;
               done = 1'b1;
            end
         end else if ($urandom_range(0, 99) >= 8) begin
            spread = price_center[sym] >> 3;
            price = price_center[sym] - spread + $urandom_range(0, 2 * spread);
         end
         send_request(mode, sym, price, side, done);
      end
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
   endtask

   task automatic test_register_map();
      check_register(REG_WINDOW);
      check_register(REG_BAND);
      check_register(REG_QTY);
      write_register(REG_WINDOW, 32'd127);
      write_register(REG_BAND, 32'd65535);
      write_register(REG_QTY, 32'hFFFF_FFFF);
      check_register(REG_WINDOW);
      check_register(REG_BAND);
      check_register(REG_QTY);
   endtask

   task automatic test_directed_intents();
      write_register(REG_WINDOW, 32'd2);
      write_register(REG_BAND, 32'd0);
      send_request(MODE_QUOTE, 4'd0, 32'h0000_0000, SIDE_BUY, 1'b0);
      send_request(MODE_QUOTE, 4'd0, 32'hFFFF_FFFF, SIDE_SELL, 1'b1);
      send_request(MODE_QUOTE, 4'd0, 32'h0000_0000, SIDE_BUY, 1'b0);
      send_request(MODE_FILL,  4'd0, 32'hFFFF_FFFF, SIDE_BUY, 1'b0);
      send_request(MODE_QUOTE, 4'd0, 32'hFFFF_FFFF, SIDE_BUY, 1'b0);
      send_request(MODE_FILL,  4'd0, 32'h0000_0000, SIDE_BUY, 1'b1);
      send_request(MODE_QUOTE, 4'd0, 32'h0000_0000, SIDE_BUY, 1'b0);
      send_request(MODE_QUOTE, 4'd0, 32'hFFFF_FFFF, SIDE_BUY, 1'b0);
      send_request(MODE_FILL,  4'd0, 32'h0000_0000, SIDE_SELL, 1'b0);
      send_request(MODE_QUOTE, 4'd0, 32'hFFFF_FFFF, SIDE_BUY, 1'b0);
      send_request(MODE_FILL,  4'd0, 32'hA5A5_5A5A, SIDE_SELL, 1'b1);
      send_request(MODE_QUOTE, 4'd15, 32'd12345678, SIDE_SELL, 1'b1);
      send_request(MODE_QUOTE, 4'd15, 32'd12345677, SIDE_SELL, 1'b1);
      send_request(MODE_FILL,  4'd15, 32'd0, SIDE_BUY, 1'b1);
      send_request(MODE_QUOTE, 4'd15, 32'hFFFF_FFFF, SIDE_BUY, 1'b0);
      settle_pipeline();
      write_register(REG_BAND, 32'd65535);
      write_register(REG_QTY, 32'd0);
      send_request(MODE_QUOTE, 4'd15, 32'h0000_0000, SIDE_BUY, 1'b0);
      send_request(MODE_QUOTE, 4'd15, 32'hFFFF_FFFF, SIDE_BUY, 1'b0);
      send_request(MODE_QUOTE, 4'd15, 32'h0000_0000, SIDE_BUY, 1'b0);
      send_request(MODE_FILL,  4'd15, 32'h5A5A_A5A5, SIDE_BUY, 1'b1);
      send_request(MODE_QUOTE, 4'd15, 32'hFFFF_FFFF, SIDE_BUY, 1'b0);
      send_request(MODE_QUOTE, 4'd15, 32'h0000_0001, SIDE_BUY, 1'b0);
      settle_pipeline();
   endtask

   task automatic test_wide_window();
      for (int s = 0; s < NUM_SYMBOLS_DEF; s++)
         price_center[s] = $urandom_range(16, 32'h7FFF_FFFF);
      // above the maximum, acts as the full ring
      write_register(REG_WINDOW, 32'd127);
      write_register(REG_BAND, 32'd3277);
      write_register(REG_QTY, $urandom);
      run_quote_stream(500, 0, 4'($urandom_range(1, 7)), 4'($urandom_range(8, 14)));
      settle_pipeline();
   endtask

   task automatic test_shrunk_window();
      write_register(REG_WINDOW, 32'd16);
      write_register(REG_BAND, $urandom_range(1000, 8000));
      write_register(REG_QTY, 32'hFFFF_FFFF);
      run_quote_stream(500, 250, 4'($urandom_range(1, 14)), 4'($urandom_range(1, 14)));
      settle_pipeline();
   endtask

   task automatic test_back_pressure();
      write_register(REG_WINDOW, 32'd3);
      write_register(REG_BAND, 32'd0);
      write_register(REG_QTY, $urandom);
      long_stall_armed = 1'b1;
      run_quote_stream(400, 0, 4'($urandom_range(1, 14)), 4'($urandom_range(1, 14)));
      settle_pipeline();
   endtask

   task automatic test_unit_window();
      write_register(REG_WINDOW, 32'd1);
      write_register(REG_BAND, 32'd65535);
      write_register(REG_QTY, $urandom);
      run_quote_stream(100, 0, 4'($urandom_range(1, 14)), 4'($urandom_range(1, 14)));
      settle_pipeline();
   endtask

   task automatic test_zero_window();
      write_register(REG_WINDOW, 32'd0);
      write_register(REG_BAND, $urandom_range(0, 65535));
      write_register(REG_QTY, 32'd0);
      run_quote_stream(100, 0, 4'($urandom_range(1, 14)), 4'($urandom_range(1, 14)));
      settle_pipeline();
   endtask

   // result side flow control
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_armed) begin
            rsp_tready <= 1'b0;
            repeat (LONG_STALL) @(negedge clock);
            long_stall_armed = 1'b0;
         end
         rsp_tready <= receiver_steady || ($urandom_range(0, 99) >= 20);
      end
   end

   task automatic report_field(input string field_name, input logic [63:0] expected_value,
                               input logic [63:0] actual_value);
      if (expected_value !== actual_value) begin
         mismatch_count++;
         $display("%0t: intent %s expected %0h, got %0h",
                  $time, field_name, expected_value, actual_value);
      end
   endtask

   always @(posedge clock) begin
      intent_type expected_intent;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_intents.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected intent, expected none, got %0h side %0b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            expected_intent = pending_intents.pop_front();
            intents_checked++;
            report_field("symbol", 64'(expected_intent.sym), 64'(rsp_tdata[3:0]));
            report_field("side", 64'(expected_intent.side), 64'(rsp_tuser));
            report_field("quantity", 64'(expected_intent.quantity), 64'(rsp_tdata[35:4]));
            report_field("quote price", 64'(expected_intent.quote_price),
                         64'(rsp_tdata[67:36]));
         end
      end
   end

   initial begin
      #(CLOCK_PERIOD * RUN_LIMIT_CYCLES);
      $display("%0t: run limit reached with %0d intents outstanding",
               $time, pending_intents.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      mismatch_count = 0;
      requests_accepted = 0;
      intents_checked = 0;
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
      long_stall_armed = 1'b0;
      window_setting = WINDOW_RESET;
      band_setting = BAND_RESET;
      quantity_setting = QTY_RESET;
      for (int s = 0; s < NUM_SYMBOLS_DEF; s++) begin
         window_sum[s] = '0;
         window_count[s] = '0;
         next_slot[s] = '0;
         symbol_held[s] = 1'b0;
         price_center[s] = '0;
         for (int k = 0; k < MAX_WINDOW_DEF; k++) begin
            ring_price[s][k] = '0;
            ring_filled[s][k] = 1'b0;
         end
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_map();
      test_directed_intents();
      test_wide_window();
      test_shrunk_window();
      test_back_pressure();
      test_unit_window();
      test_zero_window();

      $display("run covered %0d requests and %0d trade intents", requests_accepted,
               intents_checked);
      $display("windows 2, 64, 16, 3, 1 and 0, band and quantity extremes, one long stall");
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
